@@ hw/rtl/rbb_pkg.sv @@
// Shared types, constants and the quarter-wave sine generator for the rotated box bounds block.
// No dependencies; imported by rotated_box_bounds.
package rbb_pkg;

   // Angle resolution: 2^RBB_ANGLE_BITS steps per full turn
   localparam int RBB_ANGLE_BITS = 12;
   // Default fraction bits of cos and sin (Q2.F)
   localparam int RBB_TRIG_FRAC_BITS = 14;
   // Coordinate width, signed Q16.16
   localparam int RBB_COORD_W = 32;

   // pi/2 in Q1.30
   localparam logic [63:0] SIN_PIH30 = 64'd1686629713;
   // Taylor divisors (2n)(2n+1) for n = 1..7
   localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210};

   typedef struct packed {
      logic signed [RBB_COORD_W-1:0] box_min_x;
      logic signed [RBB_COORD_W-1:0] box_min_y;
      logic signed [RBB_COORD_W-1:0] box_max_x;
      logic signed [RBB_COORD_W-1:0] box_max_y;
      logic signed [RBB_COORD_W-1:0] shift_x;
      logic signed [RBB_COORD_W-1:0] shift_y;
      logic [RBB_ANGLE_BITS-1:0]     turn_angle;
   } rbb_req_type;

   typedef struct packed {
      logic signed [RBB_COORD_W-1:0] new_min_x;
      logic signed [RBB_COORD_W-1:0] new_min_y;
      logic signed [RBB_COORD_W-1:0] new_max_x;
      logic signed [RBB_COORD_W-1:0] new_max_y;
   } rbb_rsp_type;

   // sin(pi/2 * k / Q) in Q2.frac_bits with Q = 2^(angle_bits-2); evaluated at elaboration
   function automatic logic [63:0] quarter_sin(input logic [63:0] k, input int angle_bits,
                                               input int frac_bits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] r;
      int                 n;
      x    = (SIN_PIH30 * k) >> (angle_bits - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
         if ((n % 2) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      r = (sum + (64'sd1 <<< (29 - frac_bits))) >>> (30 - frac_bits);
      if (r > (64'sd1 <<< frac_bits)) begin
         r = 64'sd1 <<< frac_bits;
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/rotated_box_bounds.sv @@
// Rotated box bounds: rotates the four corners of a box, translates them and returns their bounds.
// Depends on rbb_pkg (payload types, sine table generator).
//
// Usage:
//   req channel: one beat carries a box (min and max corners), a translation and
//   a counterclockwise angle in 2^RBB_ANGLE_BITS steps per turn. rsp channel: one
//   beat per request with the min and max of the transformed corners, each
//   coordinate saturated to 32-bit signed Q16.16.
//   Four register stages: sine lookup, products, corner sums, bounds. A beat
//   accepted on req passes through them in that order and leaves from bounds.
//   Throughput is one beat per cycle while rsp_ready is high; no stage depends on an earlier beat.
//   The sine table is a constant ROM of 2^(RBB_ANGLE_BITS-2)+1 entries with a
//   registered read, read at two addresses (sin and cos) per beat.
//   Each stage moves whenever the stage after it is empty or moving, so bubbles
//   close up and req_ready stays high while a result waits and a stage is free.
//   When rsp_ready stays low the pipeline fills, holds up to four beats, and
//   then drops req_ready. Nothing is lost or duplicated.
//   Reset (synchronous, active high) clears all valid flags; the block needs no
//   warm-up and can take a beat as soon as reset is released.
module rotated_box_bounds #(
   parameter int TRIG_FRAC_BITS = rbb_pkg::RBB_TRIG_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rbb_pkg::rbb_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rbb_pkg::rbb_rsp_type rsp_data
);
   import rbb_pkg::*;

   localparam int QSIZE   = 1 << (RBB_ANGLE_BITS - 2);
   localparam int ROM_AW  = RBB_ANGLE_BITS - 1;
   localparam int SIN_W   = TRIG_FRAC_BITS + 1;
   localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
   localparam int PROD_W  = RBB_COORD_W + TRIG_W;
   localparam int TERM_W  = PROD_W - TRIG_FRAC_BITS;
   localparam int SUM_W   = TERM_W + 2;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // Corner order: (min,min), (min,max), (max,max), (max,min); 0 selects min, 1 max
   localparam logic CORNER_XSEL [4] = '{1'b0, 1'b0, 1'b1, 1'b1};
   localparam logic CORNER_YSEL [4] = '{1'b0, 1'b1, 1'b1, 1'b0};

   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

   // Clamp a wide sum to 32-bit signed
   function automatic logic signed [RBB_COORD_W-1:0] sat_coord(
      input logic signed [SUM_W-1:0] v);
      logic signed [RBB_COORD_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[RBB_COORD_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[RBB_COORD_W-1:0];
      end else begin
         r = v[RBB_COORD_W-1:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- sine ROM
   logic [SIN_W-1:0] sine_rom [QSIZE+1];

   for (genvar k = 0; k <= QSIZE; k++) begin : g_rom
      assign sine_rom[k] = SIN_W'(quarter_sin(64'(k), RBB_ANGLE_BITS, TRIG_FRAC_BITS));
   end

   // ---------------------------------------------------------------- handshake
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in;
   logic ld1, ld2, ld3, ld4;

   // A stage loads when it is empty or its beat moves on
   assign ld4 = !s4_valid_ff || rsp_ready;
   assign ld3 = !s3_valid_ff || ld4;
   assign ld2 = !s2_valid_ff || ld3;
   assign ld1 = !s1_valid_ff || ld2;

   assign req_ready = ld1;
   assign rsp_valid = s4_valid_ff;

   assign s1_valid_in = ld1 ? req_valid   : s1_valid_ff;
   assign s2_valid_in = ld2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = ld3 ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in = ld4 ? s3_valid_ff : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   // ---------------------------------------------------------------- stage 1: sine lookup
   logic [RBB_ANGLE_BITS-3:0]     q_off;
   logic [ROM_AW-1:0]             sin_addr, cos_addr;
   logic [SIN_W-1:0]              sin_in, cos_in;
   logic [SIN_W-1:0]              sin_ff, cos_ff;
   logic [1:0]                    quad_ff;
   logic signed [RBB_COORD_W-1:0] bx_ff [2];
   logic signed [RBB_COORD_W-1:0] by_ff [2];
   logic signed [RBB_COORD_W-1:0] tx1_ff, ty1_ff;

   assign q_off    = req_data.turn_angle[RBB_ANGLE_BITS-3:0];
   assign sin_addr = ROM_AW'(q_off);
   assign cos_addr = ROM_AW'(QSIZE) - ROM_AW'(q_off);
   assign sin_in   = sine_rom[sin_addr];
   assign cos_in   = sine_rom[cos_addr];

   always_ff @(posedge clock) begin
      if (ld1 && req_valid) begin
         sin_ff  <= sin_in;
         cos_ff  <= cos_in;
         quad_ff <= req_data.turn_angle[RBB_ANGLE_BITS-1:RBB_ANGLE_BITS-2];
         bx_ff[0] <= req_data.box_min_x;
         bx_ff[1] <= req_data.box_max_x;
         by_ff[0] <= req_data.box_min_y;
         by_ff[1] <= req_data.box_max_y;
         tx1_ff  <= req_data.shift_x;
         ty1_ff  <= req_data.shift_y;
      end
   end

   // ---------------------------------------------------------------- stage 2: products
   logic signed [TRIG_W-1:0]      s_pos, c_pos, cs, sn;
   logic signed [PROD_W-1:0]      px_cs_in [2];
   logic signed [PROD_W-1:0]      px_sn_in [2];
   logic signed [PROD_W-1:0]      py_cs_in [2];
   logic signed [PROD_W-1:0]      py_sn_in [2];
   logic signed [PROD_W-1:0]      px_cs_ff [2];
   logic signed [PROD_W-1:0]      px_sn_ff [2];
   logic signed [PROD_W-1:0]      py_cs_ff [2];
   logic signed [PROD_W-1:0]      py_sn_ff [2];
   logic signed [RBB_COORD_W-1:0] tx2_ff, ty2_ff;

   assign s_pos = $signed({1'b0, sin_ff});
   assign c_pos = $signed({1'b0, cos_ff});

   // Map the quadrant onto signed cos and sin
   always_comb begin
      case (quad_ff)
         QUAD_0: begin
            cs = c_pos;
            sn = s_pos;
         end
         QUAD_1: begin
            cs = -s_pos;
            sn = c_pos;
         end
         QUAD_2: begin
            cs = -c_pos;
            sn = -s_pos;
         end
         QUAD_3: begin
            cs = s_pos;
            sn = -c_pos;
         end
         default: begin
            cs = c_pos;
            sn = s_pos;
         end
      endcase
   end

   for (genvar m = 0; m < 2; m++) begin : g_mul
      assign px_cs_in[m] = bx_ff[m] * cs;
      assign px_sn_in[m] = bx_ff[m] * sn;
      assign py_cs_in[m] = by_ff[m] * cs;
      assign py_sn_in[m] = by_ff[m] * sn;
   end

   always_ff @(posedge clock) begin
      if (ld2 && s1_valid_ff) begin
         px_cs_ff <= px_cs_in;
         px_sn_ff <= px_sn_in;
         py_cs_ff <= py_cs_in;
         py_sn_ff <= py_sn_in;
         tx2_ff   <= tx1_ff;
         ty2_ff   <= ty1_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3: corner sums
   logic signed [RBB_COORD_W-1:0] cx_in [4];
   logic signed [RBB_COORD_W-1:0] cy_in [4];
   logic signed [RBB_COORD_W-1:0] cx_ff [4];
   logic signed [RBB_COORD_W-1:0] cy_ff [4];

   // Drop the fraction bits (floor), add translation, saturate
   always_comb begin
      logic signed [TERM_W-1:0] a_xc, a_ys, a_xs, a_yc;
      logic signed [SUM_W-1:0]  sx, sy;
      for (int i = 0; i < 4; i++) begin
         a_xc = px_cs_ff[CORNER_XSEL[i]][PROD_W-1:TRIG_FRAC_BITS];
         a_xs = px_sn_ff[CORNER_XSEL[i]][PROD_W-1:TRIG_FRAC_BITS];
         a_yc = py_cs_ff[CORNER_YSEL[i]][PROD_W-1:TRIG_FRAC_BITS];
         a_ys = py_sn_ff[CORNER_YSEL[i]][PROD_W-1:TRIG_FRAC_BITS];
         sx = SUM_W'(a_xc) - SUM_W'(a_ys) + SUM_W'(tx2_ff);
         sy = SUM_W'(a_xs) + SUM_W'(a_yc) + SUM_W'(ty2_ff);
         cx_in[i] = sat_coord(sx);
         cy_in[i] = sat_coord(sy);
      end
   end

   always_ff @(posedge clock) begin
      if (ld3 && s2_valid_ff) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
      end
   end

   // ---------------------------------------------------------------- stage 4: bounds
   rbb_rsp_type rsp_in, rsp_ff;

   // Pairwise tree over the four corners
   always_comb begin
      logic signed [RBB_COORD_W-1:0] lx0, lx1, hx0, hx1, ly0, ly1, hy0, hy1;
      lx0 = (cx_ff[1] < cx_ff[0]) ? cx_ff[1] : cx_ff[0];
      lx1 = (cx_ff[3] < cx_ff[2]) ? cx_ff[3] : cx_ff[2];
      hx0 = (cx_ff[1] > cx_ff[0]) ? cx_ff[1] : cx_ff[0];
      hx1 = (cx_ff[3] > cx_ff[2]) ? cx_ff[3] : cx_ff[2];
      ly0 = (cy_ff[1] < cy_ff[0]) ? cy_ff[1] : cy_ff[0];
      ly1 = (cy_ff[3] < cy_ff[2]) ? cy_ff[3] : cy_ff[2];
      hy0 = (cy_ff[1] > cy_ff[0]) ? cy_ff[1] : cy_ff[0];
      hy1 = (cy_ff[3] > cy_ff[2]) ? cy_ff[3] : cy_ff[2];
      rsp_in.new_min_x = (lx1 < lx0) ? lx1 : lx0;
      rsp_in.new_max_x = (hx1 > hx0) ? hx1 : hx0;
      rsp_in.new_min_y = (ly1 < ly0) ? ly1 : ly0;
      rsp_in.new_max_y = (hy1 > hy0) ? hy1 : hy0;
   end

   always_ff @(posedge clock) begin
      if (ld4 && s3_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ tb/rbb_bounds_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for rotated_box_bounds: predicts the bounds of every request beat and
// checks the response beats against them in order. Depends on rbb_pkg for the payload types.
module rbb_bounds_checker #(
   parameter int FRAC_BITS = rbb_pkg::RBB_TRIG_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  rbb_pkg::rbb_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rbb_pkg::rbb_rsp_type rsp_data,
   output int                   mismatch_count,
   output int                   bounds_pending
);
   import rbb_pkg::*;

   typedef enum logic [1:0] {TURN_0, TURN_90, TURN_180, TURN_270} quadrant_type;

   localparam int              STEP_BITS   = RBB_ANGLE_BITS - 2;
   localparam int              QUARTER     = 1 << STEP_BITS;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint          COORD_MAX   = 64'sd2147483647;
   localparam longint          COORD_MIN   = -64'sd2147483648;

   longint      sine_rom [0:QUARTER];
   rbb_rsp_type expected_bounds [$];

   // sin(pi/2 * k / QUARTER) in Q2.FRAC_BITS from a Taylor series in Q1.30
   function automatic longint sine_point(input longint unsigned k);
      longint unsigned angle_q30;
      longint unsigned angle_sq;
      longint unsigned term;
      longint unsigned divisor;
      longint          acc;
      longint          rounded;
      angle_q30 = (HALF_PI_Q30 * k) >> STEP_BITS;
      angle_sq  = (angle_q30 * angle_q30) >> 30;
      term      = angle_q30;
      acc       = longint'(angle_q30);
      for (int n = 1; n <= 7; n++) begin
         divisor = longint'(2 * n * (2 * n + 1));
         term    = ((term * angle_sq) >> 30) / divisor;
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      // round half up to the output fraction, cap at exactly one
      rounded = (acc + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      if (rounded > (64'sd1 <<< FRAC_BITS)) begin
         rounded = 64'sd1 <<< FRAC_BITS;
      end
      return rounded;
   endfunction

   function automatic longint clamp_coord(input longint v);
      if (v > COORD_MAX) begin
         return COORD_MAX;
      end
      if (v < COORD_MIN) begin
         return COORD_MIN;
      end
      return v;
   endfunction

   // Rotate the four corners, translate, saturate, and take their bounds
   function automatic rbb_rsp_type predict_bounds(input rbb_req_type box);
      quadrant_type quadrant;
      int          step;
      longint      s_val;
      longint      c_val;
      longint      cos_v;
      longint      sin_v;
      longint      mnx, mny, mxx, mxy, tx, ty;
      longint      cx [4];
      longint      cy [4];
      longint      nx, ny;
      longint      lo_x, lo_y, hi_x, hi_y;
      rbb_rsp_type bounds;
      quadrant = quadrant_type'(box.turn_angle[RBB_ANGLE_BITS-1 -: 2]);
      step     = int'(box.turn_angle[STEP_BITS-1:0]);
      s_val    = sine_rom[step];
      c_val    = sine_rom[QUARTER - step];
      case (quadrant)
         TURN_0: begin
            cos_v = c_val;
            sin_v = s_val;
         end
         TURN_90: begin
            cos_v = -s_val;
            sin_v = c_val;
         end
         TURN_180: begin
            cos_v = -c_val;
            sin_v = -s_val;
         end
         default: begin
            cos_v = s_val;
            sin_v = -c_val;
         end
      endcase
      mnx = $signed(box.box_min_x);
      mny = $signed(box.box_min_y);
      mxx = $signed(box.box_max_x);
      mxy = $signed(box.box_max_y);
      tx  = $signed(box.shift_x);
      ty  = $signed(box.shift_y);
      // corners in order: (min,min), (min,max), (max,max), (max,min)
      cx = '{mnx, mnx, mxx, mxx};
      cy = '{mny, mxy, mxy, mny};
      lo_x = 0;
      lo_y = 0;
      hi_x = 0;
      hi_y = 0;
      for (int i = 0; i < 4; i++) begin
         nx = clamp_coord(((cx[i] * cos_v) >>> FRAC_BITS) - ((cy[i] * sin_v) >>> FRAC_BITS) + tx);
         ny = clamp_coord(((cx[i] * sin_v) >>> FRAC_BITS) + ((cy[i] * cos_v) >>> FRAC_BITS) + ty);
         if (i == 0 || nx < lo_x) lo_x = nx;
         if (i == 0 || nx > hi_x) hi_x = nx;
         if (i == 0 || ny < lo_y) lo_y = ny;
         if (i == 0 || ny > hi_y) hi_y = ny;
      end
      bounds.new_min_x = lo_x[31:0];
      bounds.new_min_y = lo_y[31:0];
      bounds.new_max_x = hi_x[31:0];
      bounds.new_max_y = hi_y[31:0];
      return bounds;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d, expected %0d", field, $signed(got),
                                   $signed(want)));
      end
   endtask

   initial begin
      for (int k = 0; k <= QUARTER; k++) begin
         sine_rom[k] = sine_point(longint'(k));
      end
   end

   always @(posedge clock) begin
      rbb_rsp_type want;
      if (!reset) begin
         // retire a response beat first so a same-edge request cannot satisfy it
         if (rsp_valid && rsp_ready) begin
            if (expected_bounds.size() == 0) begin
               report_mismatch("response beat with no request outstanding");
            end else begin
               want = expected_bounds.pop_front();
               check_field("new_min_x", rsp_data.new_min_x, want.new_min_x);
               check_field("new_min_y", rsp_data.new_min_y, want.new_min_y);
               check_field("new_max_x", rsp_data.new_max_x, want.new_max_x);
               check_field("new_max_y", rsp_data.new_max_y, want.new_max_y);
            end
         end
         if (req_valid && req_ready) begin
            expected_bounds.push_back(predict_bounds(req_data));
         end
      end
      bounds_pending <= expected_bounds.size();
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Top of the rotated_box_bounds testbench: clock, reset, request and response traffic, verdict.
// Depends on rbb_pkg, rotated_box_bounds and rbb_bounds_checker.
module testbench;
   import rbb_pkg::*;

   localparam int                FRAC_BITS    = RBB_TRIG_FRAC_BITS;
   localparam int                RANDOM_BOXES = 1600;
   localparam int                CYCLE_LIMIT  = 200000;
   localparam int                DRAIN_CYCLES = 10;
   localparam int                QUARTER_TURN = 1 << (RBB_ANGLE_BITS - 2);
   localparam int                FULL_TURN    = 1 << RBB_ANGLE_BITS;
   localparam logic signed [31:0] COORD_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] COORD_MIN   = 32'sh8000_0000;
   localparam logic signed [31:0] ONE         = 32'sh0001_0000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   rbb_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rbb_rsp_type rsp_data;
   int          mismatch_count;
   int          bounds_pending;
   int          cycle_count;
   rbb_req_type directed_boxes [$];

   rotated_box_bounds #(.TRIG_FRAC_BITS(FRAC_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   rbb_bounds_checker #(.FRAC_BITS(FRAC_BITS)) bounds_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .bounds_pending (bounds_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic add_box(input logic signed [31:0] mnx, input logic signed [31:0] mny,
                          input logic signed [31:0] mxx, input logic signed [31:0] mxy,
                          input logic signed [31:0] sx, input logic signed [31:0] sy,
                          input int angle);
      rbb_req_type box;
      box.box_min_x  = mnx;
      box.box_min_y  = mny;
      box.box_max_x  = mxx;
      box.box_max_y  = mxy;
      box.shift_x    = sx;
      box.shift_y    = sy;
      box.turn_angle = angle[RBB_ANGLE_BITS-1:0];
      directed_boxes.push_back(box);
   endtask

   function automatic logic signed [31:0] span(input int unsigned half);
      return int'($urandom_range(0, 2 * half)) - int'(half);
   endfunction

   function automatic logic signed [31:0] near_edge();
      if ($urandom_range(0, 1) == 1) begin
         return COORD_MAX - $urandom_range(0, 1 << 20);
      end
      return COORD_MIN + $urandom_range(0, 1 << 20);
   endfunction

   // Mostly boxes at random scales, some with swapped corners; the rest raw noise or saturating coordinates
   function automatic rbb_req_type random_box();
      rbb_req_type         box;
      int unsigned         pick;
      int unsigned         scale;
      int                  angle;
      logic signed [31:0]  held;
      pick           = $urandom_range(0, 99);
      box.turn_angle = RBB_ANGLE_BITS'($urandom_range(0, FULL_TURN - 1));
      if (pick < 25) begin
         box.box_min_x = $urandom;
         box.box_min_y = $urandom;
         box.box_max_x = $urandom;
         box.box_max_y = $urandom;
         box.shift_x   = $urandom;
         box.shift_y   = $urandom;
      end else if (pick < 40) begin
         box.box_min_x = near_edge();
         box.box_min_y = near_edge();
         box.box_max_x = near_edge();
         box.box_max_y = near_edge();
         box.shift_x   = near_edge();
         box.shift_y   = near_edge();
      end else begin
         scale         = 1 << $urandom_range(4, 28);
         box.box_min_x = span(scale);
         box.box_min_y = span(scale);
         box.box_max_x = box.box_min_x + $urandom_range(0, scale);
         box.box_max_y = box.box_min_y + $urandom_range(0, scale);
         box.shift_x   = span(scale);
         box.shift_y   = span(scale);
         // swap the x corners, and for some boxes the y corners too, so min is not below max
         if (pick < 50) begin
            held          = box.box_min_x;
            box.box_min_x = box.box_max_x;
            box.box_max_x = held;
            if (pick < 45) begin
               held          = box.box_min_y;
               box.box_min_y = box.box_max_y;
               box.box_max_y = held;
            end
         end
         // land on or next to a quadrant boundary
         if (pick >= 85) begin
            angle = int'($urandom_range(0, 3)) * QUARTER_TURN + int'($urandom_range(0, 4)) - 2;
            box.turn_angle = angle[RBB_ANGLE_BITS-1:0];
         end
      end
      return box;
   endfunction

   // Receiver: random stalls between beats, with stretches of steady ready
   initial begin
      int stall;
      int taken;
      bit steady;
      rsp_ready <= 1'b0;
      taken = 0;
      steady = 1'b0;
      @(posedge clock);
      forever begin
         if (taken % 64 == 0) begin
            steady = ($urandom_range(0, 3) == 0);
         end
         stall = steady ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // Sender: directed boxes, then random ones, then drain and judge
   initial begin
      rbb_req_type box;
      int          gap;
      int          total;
      bit          steady;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      steady = 1'b0;

      add_box(0, 0, 0, 0, 0, 0, 0);
      add_box(0, 0, ONE, ONE, 0, 0, 0);
      add_box(0, 0, ONE, ONE, 0, 0, QUARTER_TURN);
      add_box(0, 0, ONE, ONE, 0, 0, 2 * QUARTER_TURN);
      add_box(0, 0, ONE, ONE, 0, 0, 3 * QUARTER_TURN);
      add_box(0, 0, ONE, ONE, 0, 0, FULL_TURN - 1);
      add_box(-ONE, -ONE, ONE, ONE, 0, 0, 1);
      add_box(-ONE, -2 * ONE, 3 * ONE, ONE, 5 * ONE, -7 * ONE, QUARTER_TURN / 2);
      add_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
              FULL_TURN - 1);
      add_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 0);
      add_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0, QUARTER_TURN / 2);
      // push corners past the top and the bottom of the range
      add_box(32'sh4000_0000, 0, 32'sh7000_0000, ONE, COORD_MAX, COORD_MAX, 0);
      add_box(COORD_MIN, COORD_MIN, -ONE, -ONE, COORD_MIN, COORD_MIN, 0);
      add_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 2 * QUARTER_TURN);
      // reversed boxes, then a zero-size box and one with fractional corners
      add_box(10 * ONE, 10 * ONE, -10 * ONE, -10 * ONE, ONE, -ONE, 300);
      add_box(5 * ONE, -ONE, -3 * ONE, 2 * ONE, 0, 0, 3 * QUARTER_TURN + 100);
      add_box(0, 0, 0, 0, COORD_MAX, COORD_MIN, 2 * QUARTER_TURN + 1);
      add_box(32'sh0000_8001, 32'shFFFF_7FFF, 32'sh0001_8001, 32'sh0000_0001, 32'sh0000_0001,
              32'shFFFF_FFFF, QUARTER_TURN - 1);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      total = directed_boxes.size() + RANDOM_BOXES;
      for (int n = 0; n < total; n++) begin
         box = (n < directed_boxes.size()) ? directed_boxes[n] : random_box();
         if (n % 64 == 0) begin
            steady = ($urandom_range(0, 3) == 0);
         end
         gap = steady ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= box;
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;

      // wait out the pipeline, then let stray beats show up
      do @(posedge clock); while (bounds_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/rbb_pkg.sv
hw/rtl/rotated_box_bounds.sv
tb/rbb_bounds_checker.sv
tb/testbench.sv
